@@ rtl/bldu_pkg.sv @@
// ----------------------------------------------------------------------------
// bldu_pkg
// Shared codes and word types for the bounded list insert/delete/dump unit.
// ----------------------------------------------------------------------------
package bldu_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 16;
  localparam int STATUS_W = 2;

  // operation codes on the kind field
  localparam logic [KIND_W-1:0] KIND_HEAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAIL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // status codes carried on every result word of a run
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  // tag that travels alongside a memory read during a dump
  typedef struct packed {
    logic                valid;
    logic                dir;
    logic                has;
    logic                last;
    logic [STATUS_W-1:0] status;
  } dump_tag_t;

  // one result word as held in the output queue
  typedef struct packed {
    logic                dir;
    logic [VALUE_W-1:0]  value;
    logic                has;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_word_t;

endpackage

@@ rtl/bldu_mem.sv @@
// ----------------------------------------------------------------------------
// bldu_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bldu_mem #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bldu_ctrl.sv @@
// ----------------------------------------------------------------------------
// bldu_ctrl
// Sequencer: applies inserts and deletes to the circular entry store, closes
// up gaps after a delete and walks the list for the two dump passes.
// ----------------------------------------------------------------------------
module bldu_ctrl #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bldu_pkg::KIND_W-1:0]    kind,
  input  logic [bldu_pkg::VALUE_W-1:0]   value,
  input  logic [bldu_pkg::INDEX_W-1:0]   index,
  input  logic [1:0]                     occ,
  output logic                           we,
  output logic [AW-1:0]                  waddr,
  output logic [WORD_WIDTH-1:0]          wdata,
  output logic [AW-1:0]                  raddr,
  input  logic [WORD_WIDTH-1:0]          rd_data,
  output bldu_pkg::dump_tag_t            tag
);

  import bldu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SH_RD = 4'b0010,
    S_SH_WR = 4'b0100,
    S_DUMP  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       pos, pos_next;
  logic [CW-1:0]       j, j_next;
  logic                dir, dir_next;
  logic [STATUS_W-1:0] stat, stat_next;
  dump_tag_t           tag_next;
  logic [63:0]         value_wide;
  logic [WORD_WIDTH-1:0] word;
  logic [2:0]          credit;
  logic [CW:0]         idx_plus1;
  logic [CW:0]         j_plus2;

  // physical slot of a list position
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign value_wide = 64'(value);
  assign word       = value_wide[WORD_WIDTH-1:0];
  assign credit     = 3'(occ) + 3'(tag.valid);
  assign idx_plus1  = (CW+1)'(index[CW-1:0]) + (CW+1)'(1);
  assign j_plus2    = (CW+1)'(j) + (CW+1)'(2);

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    pos_next   = pos;
    j_next     = j;
    dir_next   = dir;
    stat_next  = stat;
    tag_next   = '0;
    in_ready   = 1'b0;
    we         = 1'b0;
    waddr      = wrap_add(head, j);
    wdata      = rd_data;
    raddr      = wrap_add(head, pos);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        pos_next = '0;
        dir_next = 1'b0;
        if (in_valid) begin
          case (kind)
            KIND_HEAD, KIND_TAIL: begin
              state_next = S_DUMP;
              if (count == CW'(DEPTH)) begin
                stat_next = STAT_FULL;
              end else begin
                stat_next  = STAT_DONE;
                we         = 1'b1;
                wdata      = word;
                count_next = count + CW'(1);
                if (kind == KIND_HEAD) begin
                  head_next = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
                  waddr     = head_next;
                end else begin
                  waddr = wrap_add(head, count);
                end
              end
            end
            KIND_DELETE: begin
              if (index >= INDEX_W'(count)) begin
                stat_next  = STAT_BAD_INDEX;
                state_next = S_DUMP;
              end else begin
                stat_next = STAT_DONE;
                j_next    = index[CW-1:0];
                if (idx_plus1 == (CW+1)'(count)) begin
                  count_next = count - CW'(1);
                  state_next = S_DUMP;
                end else begin
                  state_next = S_SH_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SH_RD: begin
        raddr      = wrap_add(head, j + CW'(1));
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        // move the entry one place towards the front
        we     = 1'b1;
        j_next = j + CW'(1);
        if (j_plus2 == (CW+1)'(count)) begin
          count_next = count - CW'(1);
          state_next = S_DUMP;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_DUMP: begin
        if (credit <= 3'd2) begin
          tag_next.valid  = 1'b1;
          tag_next.dir    = dir;
          tag_next.has    = (count != '0);
          tag_next.status = stat;
          if (count == '0) begin
            tag_next.last = dir;
            if (dir) begin
              state_next = S_IDLE;
            end else begin
              dir_next = 1'b1;
            end
          end else if (!dir) begin
            if (pos == count - CW'(1)) begin
              dir_next = 1'b1;
            end else begin
              pos_next = pos + CW'(1);
            end
          end else begin
            if (pos == '0) begin
              tag_next.last = 1'b1;
              state_next    = S_IDLE;
            end else begin
              pos_next = pos - CW'(1);
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      tag   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      tag   <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    j    <= j_next;
    dir  <= dir_next;
    stat <= stat_next;
  end

endmodule

@@ rtl/bldu_out.sv @@
// ----------------------------------------------------------------------------
// bldu_out
// Three-word result queue: catches read data with its tag and holds it for
// the output channel, so the dump walk keeps going while the sink stalls until the queue is full.
// ----------------------------------------------------------------------------
module bldu_out #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bldu_pkg::dump_tag_t            tag,
  input  logic [WORD_WIDTH-1:0]          rd_data,
  output logic [1:0]                     occ,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           direction,
  output logic [bldu_pkg::VALUE_W-1:0]   entry_value,
  output logic                           has_value,
  output logic [bldu_pkg::STATUS_W-1:0]  status,
  output logic                           last
);

  import bldu_pkg::*;

  out_word_t   q [3];
  logic [1:0]  wr_ptr, rd_ptr;
  logic        push, pop;
  logic [63:0] rd_wide;
  out_word_t   in_word;

  assign rd_wide        = 64'(rd_data);
  assign in_word.dir    = tag.dir;
  assign in_word.value  = tag.has ? rd_wide[VALUE_W-1:0] : '0;
  assign in_word.has    = tag.has;
  assign in_word.status = tag.status;
  assign in_word.last   = tag.last;

  assign push      = tag.valid;
  assign out_valid = (occ != 2'd0);
  assign pop       = out_valid && out_ready;

  assign direction   = q[rd_ptr].dir;
  assign entry_value = q[rd_ptr].value;
  assign has_value   = q[rd_ptr].has;
  assign status      = q[rd_ptr].status;
  assign last        = q[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      occ <= occ + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/bounded_list_insert_delete_dump_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_dump_unit
// Ordered list of up to DEPTH words in a circular store: head insert, tail
// insert and indexed delete, each followed by a front-to-back and a
// back-to-front dump of the whole list.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | kind, value, index
//   out     | out_valid / out_ready| direction, entry_value, has_value,
//           |                      | status, last
//
// An item is taken while in_ready is high; a delete then closes the gap by
// moving each later entry one place towards the front, reading it in
// S_SH_RD and writing it in S_SH_WR. The dump walk issues one store read
// per cycle while the result queue has room; the read data and its tag are
// registered before the queue catches them.
// in_ready is high only between runs; a stall on out holds the walk once the
// three-word result queue is full. Reset clears count, head and the queue.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_dump_unit #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bldu_pkg::KIND_W-1:0]    kind,
  input  logic [bldu_pkg::VALUE_W-1:0]   value,
  input  logic [bldu_pkg::INDEX_W-1:0]   index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           direction,
  output logic [bldu_pkg::VALUE_W-1:0]   entry_value,
  output logic                           has_value,
  output logic [bldu_pkg::STATUS_W-1:0]  status,
  output logic                           last
);

  import bldu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [WORD_WIDTH-1:0] wdata, rd_data;
  logic [1:0]            occ;
  dump_tag_t             tag;

  bldu_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  bldu_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .index    (index),
    .occ      (occ),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rd_data  (rd_data),
    .tag      (tag)
  );

  bldu_out #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .tag         (tag),
    .rd_data     (rd_data),
    .occ         (occ),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .direction   (direction),
    .entry_value (entry_value),
    .has_value   (has_value),
    .status      (status),
    .last        (last)
  );

endmodule
